// ===== rtl/core/ldts_pkg.sv =====
`default_nettype none
package ldts_pkg;

   localparam int GRID_COUNT = 16;

   localparam int PADDR_W = 6;
   localparam int PDATA_W = 64;

   localparam logic [7:0] DATA_CMD     = 8'b0100_0000;
   localparam logic [7:0] DISPLAY_OFF  = 8'b1000_0000;
   localparam logic [7:0] DISPLAY_ON   = 8'b1000_1000;
   localparam logic [7:0] ADDR_CMD     = 8'b1100_0000;
   localparam logic [3:0] BRIGHT_MAX   = 4'd8;
   localparam logic [3:0] BRIGHT_STEP  = 4'h1;

   typedef enum logic [1:0] {
      CMD_SETUP      = 2'd0,
      CMD_BRIGHTNESS = 2'd1,
      CMD_GRID       = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      REG_GRID_MAP_ENABLE    = 3'd0,
      REG_GRID_MAP_LOWER     = 3'd1,
      REG_GRID_MAP_UPPER     = 3'd2,
      REG_SEGMENT_MAP_ENABLE = 3'd3,
      REG_SEGMENT_MAP        = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_DATA,
      ST_PRE_CLOCK,
      ST_START,
      ST_BIT_CLOCK_LOW,
      ST_BIT_DATA,
      ST_BIT_CLOCK_HIGH,
      ST_END_CLOCK_LOW,
      ST_END_DATA_LOW,
      ST_END_CLOCK_HIGH,
      ST_END_DATA_HIGH
   } state_type;

   typedef enum logic [2:0] {
      PIN_NONE,
      PIN_DATA_HIGH,
      PIN_DATA_LOW,
      PIN_CLOCK_HIGH,
      PIN_CLOCK_LOW,
      PIN_DATA_BIT
   } pin_op_type;

   typedef struct packed {
      logic [39:0] grid_map_lower;
      logic [39:0] grid_map_upper;
      logic [23:0] segment_map;
      logic        grid_map_enable;
      logic        segment_map_enable;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      pin_op_type pin_op;
      logic       shift;
      logic       last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic drop;
      logic setup;
      logic bits_done;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/ldts_req_if.sv =====
`default_nettype none
interface ldts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [3:0] brightness_level;
   logic [7:0] grid_number;
   logic [7:0] segment_bits;

   modport source (
      output valid, command, brightness_level, grid_number, segment_bits,
      input  ready
   );
   modport sink (
      input  valid, command, brightness_level, grid_number, segment_bits,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/core/ldts_rsp_if.sv =====
`default_nettype none
interface ldts_rsp_if;
   logic valid;
   logic ready;
   logic data_line;
   logic clock_line;
   logic last_change;

   modport source (
      output valid, data_line, clock_line, last_change,
      input  ready
   );
   modport sink (
      input  valid, data_line, clock_line, last_change,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/core/ldts_csr.sv =====
`default_nettype none
module ldts_csr import ldts_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [PADDR_W-1:0] csr_paddr,
   input  wire logic [PDATA_W-1:0] csr_pwdata,
   output logic      [PDATA_W-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[PADDR_W-1:3]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_GRID_MAP_ENABLE:    cfg_in.grid_map_enable    = csr_pwdata[0];
            REG_GRID_MAP_LOWER:     cfg_in.grid_map_lower     = csr_pwdata[39:0];
            REG_GRID_MAP_UPPER:     cfg_in.grid_map_upper     = csr_pwdata[39:0];
            REG_SEGMENT_MAP_ENABLE: cfg_in.segment_map_enable = csr_pwdata[0];
            REG_SEGMENT_MAP:        cfg_in.segment_map        = csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_GRID_MAP_ENABLE:    csr_prdata = {63'd0, cfg_ff.grid_map_enable};
         REG_GRID_MAP_LOWER:     csr_prdata = {24'd0, cfg_ff.grid_map_lower};
         REG_GRID_MAP_UPPER:     csr_prdata = {24'd0, cfg_ff.grid_map_upper};
         REG_SEGMENT_MAP_ENABLE: csr_prdata = {63'd0, cfg_ff.segment_map_enable};
         REG_SEGMENT_MAP:        csr_prdata = {40'd0, cfg_ff.segment_map};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ldts_dp.sv =====
`default_nettype none
module ldts_dp import ldts_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic [1:0]   command,
   input  wire logic [3:0]   brightness_level,
   input  wire logic [7:0]   grid_number,
   input  wire logic [7:0]   segment_bits,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_data_line,
   output logic              rsp_clock_line,
   output logic              rsp_last_change
);

   logic [15:0] shift_ff, shift_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic        two_bytes_ff, two_bytes_in;
   logic        data_level_ff, data_level_in;
   logic        clock_level_ff, clock_level_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_data_ff, rsp_clock_ff, rsp_last_ff;

   logic [39:0] map_word;
   logic [4:0]  map_entry;
   logic [3:0]  grid_final;
   logic [7:0]  segs_final;
   logic [7:0]  segs_mapped;
   logic [3:0]  level_sat;
   logic [7:0]  bright_byte;
   logic        grid_drop;
   logic [15:0] load_bytes;
   command_type cmd_code;

   assign cmd_code = command_type'(command);

   always_comb begin
      map_word  = grid_number[3] ? cfg.grid_map_upper : cfg.grid_map_lower;
      map_entry = map_word[{3'd0, grid_number[2:0]} * 6'd5 +: 5];
      grid_drop = (grid_number >= 8'(GRID_COUNT)) ||
                  (cfg.grid_map_enable && (map_entry >= 5'(GRID_COUNT)));
      grid_final = cfg.grid_map_enable ? map_entry[3:0] : grid_number[3:0];

      segs_mapped = '0;
      for (int i = 0; i < 8; i++) begin
         if (segment_bits[i]) begin
            segs_mapped[cfg.segment_map[3*i +: 3]] = 1'b1;
         end
      end
      segs_final = cfg.segment_map_enable ? segs_mapped : segment_bits;

      level_sat   = (brightness_level > BRIGHT_MAX) ? BRIGHT_MAX : brightness_level;
      bright_byte = (level_sat == '0) ? DISPLAY_OFF :
                    (DISPLAY_ON | {5'd0, 3'(level_sat - BRIGHT_STEP)});
   end

   always_comb begin
      status.drop  = 1'b0;
      status.setup = 1'b0;
      load_bytes   = '0;
      unique case (cmd_code)
         CMD_SETUP: begin
            status.setup = 1'b1;
            load_bytes   = {8'd0, DATA_CMD};
         end
         CMD_BRIGHTNESS: begin
            load_bytes = {8'd0, bright_byte};
         end
         CMD_GRID: begin
            status.drop = grid_drop;
            load_bytes  = {segs_final, ADDR_CMD | {4'd0, grid_final}};
         end
         default: begin
            status.drop = 1'b1;
         end
      endcase
      status.bits_done = (bit_cnt_ff == {two_bytes_ff, 3'b111});
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      shift_in       = shift_ff;
      bit_cnt_in     = bit_cnt_ff;
      two_bytes_in   = two_bytes_ff;
      data_level_in  = data_level_ff;
      clock_level_in = clock_level_ff;
      if (cmd.load) begin
         shift_in     = load_bytes;
         bit_cnt_in   = '0;
         two_bytes_in = (cmd_code == CMD_GRID);
      end
      if (cmd.emit) begin
         unique case (cmd.pin_op)
            PIN_DATA_HIGH:  data_level_in  = 1'b1;
            PIN_DATA_LOW:   data_level_in  = 1'b0;
            PIN_CLOCK_HIGH: clock_level_in = 1'b1;
            PIN_CLOCK_LOW:  clock_level_in = 1'b0;
            PIN_DATA_BIT:   data_level_in  = shift_ff[0];
            default: ;
         endcase
         if (cmd.shift) begin
            shift_in   = {1'b0, shift_ff[15:1]};
            bit_cnt_in = bit_cnt_ff + 4'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff     <= '0;
         two_bytes_ff   <= 1'b0;
         data_level_ff  <= 1'b1;
         clock_level_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bit_cnt_ff     <= bit_cnt_in;
         two_bytes_ff   <= two_bytes_in;
         data_level_ff  <= data_level_in;
         clock_level_ff <= clock_level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (cmd.emit) begin
         rsp_data_ff  <= data_level_in;
         rsp_clock_ff <= clock_level_in;
         rsp_last_ff  <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_line   = rsp_data_ff;
   assign rsp_clock_line  = rsp_clock_ff;
   assign rsp_last_change = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ldts_ctrl.sv =====
`default_nettype none
module ldts_ctrl import ldts_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.pin_op = PIN_NONE;
      req_ready  = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.drop) begin
                  state_in = status.setup ? ST_PRE_DATA : ST_START;
               end
            end
         end
         default: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               unique case (state_ff)
                  ST_PRE_DATA: begin
                     cmd.pin_op = PIN_DATA_HIGH;
                     state_in   = ST_PRE_CLOCK;
                  end
                  ST_PRE_CLOCK: begin
                     cmd.pin_op = PIN_CLOCK_HIGH;
                     state_in   = ST_START;
                  end
                  ST_START: begin
                     cmd.pin_op = PIN_DATA_LOW;
                     state_in   = ST_BIT_CLOCK_LOW;
                  end
                  ST_BIT_CLOCK_LOW: begin
                     cmd.pin_op = PIN_CLOCK_LOW;
                     state_in   = ST_BIT_DATA;
                  end
                  ST_BIT_DATA: begin
                     cmd.pin_op = PIN_DATA_BIT;
                     state_in   = ST_BIT_CLOCK_HIGH;
                  end
                  ST_BIT_CLOCK_HIGH: begin
                     cmd.pin_op = PIN_CLOCK_HIGH;
                     cmd.shift  = 1'b1;
                     state_in   = status.bits_done ? ST_END_CLOCK_LOW : ST_BIT_CLOCK_LOW;
                  end
                  ST_END_CLOCK_LOW: begin
                     cmd.pin_op = PIN_CLOCK_LOW;
                     state_in   = ST_END_DATA_LOW;
                  end
                  ST_END_DATA_LOW: begin
                     cmd.pin_op = PIN_DATA_LOW;
                     state_in   = ST_END_CLOCK_HIGH;
                  end
                  ST_END_CLOCK_HIGH: begin
                     cmd.pin_op = PIN_CLOCK_HIGH;
                     state_in   = ST_END_DATA_HIGH;
                  end
                  ST_END_DATA_HIGH: begin
                     cmd.pin_op = PIN_DATA_HIGH;
                     cmd.last   = 1'b1;
                     state_in   = ST_IDLE;
                  end
                  default: begin
                     cmd.emit = 1'b0;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/led_driver_two_wire_sender.sv =====
// first pin change of an item: the accept registers the sequencer state, then, once the output
// is free, the change is registered into the output stage; one pin change per cycle while the
// output is not stalled; an item holds the frame sequencer from its accept through all of its
// pin changes, and the sequencer takes the next item only after the last change
// dropped items (bad command, grid out of range or unmapped) are accepted with no pin change
// reset: synchronous, active high; both pin levels high, config, bit count and output valid zero, sequencer idle
`default_nettype none
module led_driver_two_wire_sender import ldts_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   ldts_req_if.sink                req_chan,
   ldts_rsp_if.source              rsp_chan,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [PADDR_W-1:0] csr_paddr,
   input  wire logic [PDATA_W-1:0] csr_pwdata,
   output logic      [PDATA_W-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   ldts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ldts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ldts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .command          (req_chan.command),
      .brightness_level (req_chan.brightness_level),
      .grid_number      (req_chan.grid_number),
      .segment_bits     (req_chan.segment_bits),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_data_line    (rsp_chan.data_line),
      .rsp_clock_line   (rsp_chan.clock_line),
      .rsp_last_change  (rsp_chan.last_change)
   );

endmodule
`default_nettype wire

// ===== tb/led_driver_two_wire_sender_tb.sv =====
`default_nettype none
module led_driver_two_wire_sender_tb;
   import ldts_pkg::*;

   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          ROUND_ITEMS   = 60;
   localparam logic [1:0]  CMD_UNDEFINED = 2'd3;
   localparam bit          DATA_PIN      = 1'b1;
   localparam bit          CLOCK_PIN     = 1'b0;
   localparam logic [23:0] SEG_IDENTITY  = 24'o76543210;
   localparam logic [23:0] SEG_REVERSED  = 24'o01234567;

   typedef struct {
      logic [1:0] cmd;
      logic [3:0] level;
      logic [7:0] grid;
      logic [7:0] segs;
   } command_item_type;

   typedef struct {
      logic data_line;
      logic clock_line;
      logic last_change;
   } pin_change_type;

   logic clock;
   logic reset;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [PADDR_W-1:0] csr_paddr;
   logic [PDATA_W-1:0] csr_pwdata;
   wire  [PDATA_W-1:0] csr_prdata;
   wire                csr_pready;

   ldts_req_if req_if ();
   ldts_rsp_if rsp_if ();

   led_driver_two_wire_sender dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   command_item_type command_queue[$];
   pin_change_type   expected_pins[$];
   cfg_type          cfg_mirror;
   bit               data_level;
   bit               clock_level;
   int               tx_idle_pct;
   int               rx_idle_pct;
   int               fail_count;
   int               cycle_count;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // pin-level predictor
   function automatic void emit_pin(bit on_data, bit lvl, bit last);
      pin_change_type p;
      if (on_data) data_level = lvl;
      else clock_level = lvl;
      p.data_line   = data_level;
      p.clock_line  = clock_level;
      p.last_change = last;
      expected_pins.push_back(p);
   endfunction

   function automatic void emit_byte(logic [7:0] value);
      for (int b = 0; b < 8; b++) begin
         emit_pin(CLOCK_PIN, 1'b0, 1'b0);
         emit_pin(DATA_PIN, value[b], 1'b0);
         emit_pin(CLOCK_PIN, 1'b1, 1'b0);
      end
   endfunction

   function automatic void emit_frame(logic [7:0] first, logic [7:0] second, bit two_bytes);
      emit_pin(DATA_PIN, 1'b0, 1'b0);
      emit_byte(first);
      if (two_bytes) emit_byte(second);
      emit_pin(CLOCK_PIN, 1'b0, 1'b0);
      emit_pin(DATA_PIN, 1'b0, 1'b0);
      emit_pin(CLOCK_PIN, 1'b1, 1'b0);
      emit_pin(DATA_PIN, 1'b1, 1'b1);
   endfunction

   function automatic void predict_pin_sequence(command_item_type it);
      logic [3:0]  level;
      logic [4:0]  grid;
      logic [39:0] word;
      logic [7:0]  segs;
      case (it.cmd)
         CMD_SETUP: begin
            emit_pin(DATA_PIN, 1'b1, 1'b0);
            emit_pin(CLOCK_PIN, 1'b1, 1'b0);
            emit_frame(DATA_CMD, 8'h00, 1'b0);
         end
         CMD_BRIGHTNESS: begin
            level = (it.level > BRIGHT_MAX) ? BRIGHT_MAX : it.level;
            if (level == 4'd0) emit_frame(DISPLAY_OFF, 8'h00, 1'b0);
            else emit_frame(DISPLAY_ON | {4'd0, level - BRIGHT_STEP}, 8'h00, 1'b0);
         end
         CMD_GRID: begin
            if (it.grid < GRID_COUNT) begin
               grid = it.grid[4:0];
               if (cfg_mirror.grid_map_enable) begin
                  word = (it.grid < 8) ? cfg_mirror.grid_map_lower : cfg_mirror.grid_map_upper;
                  grid = word[it.grid[2:0] * 5 +: 5];
               end
               if (grid < GRID_COUNT) begin
                  segs = it.segs;
                  if (cfg_mirror.segment_map_enable) begin
                     segs = 8'h00;
                     for (int i = 0; i < 8; i++)
                        if (it.segs[i]) segs[cfg_mirror.segment_map[3*i +: 3]] = 1'b1;
                  end
                  emit_frame(ADDR_CMD | {4'd0, grid[3:0]}, segs, 1'b1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // command driver
   always @(posedge clock) begin : drive_commands
      command_item_type it;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            it.cmd   = req_if.command;
            it.level = req_if.brightness_level;
            it.grid  = req_if.grid_number;
            it.segs  = req_if.segment_bits;
            predict_pin_sequence(it);
         end
         if (!req_if.valid || req_if.ready) begin
            if (command_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               it = command_queue.pop_front();
               req_if.valid            <= 1'b1;
               req_if.command          <= it.cmd;
               req_if.brightness_level <= it.level;
               req_if.grid_number      <= it.grid;
               req_if.segment_bits     <= it.segs;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // pin change checker
   always @(posedge clock) begin : check_pins
      pin_change_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pins.size() == 0) begin
               $error("unexpected pin change: data %0b clock %0b last %0b",
                      rsp_if.data_line, rsp_if.clock_line, rsp_if.last_change);
               fail_count++;
            end else begin
               want = expected_pins.pop_front();
               if (rsp_if.data_line !== want.data_line) begin
                  $error("data_line: expected %0b, got %0b", want.data_line, rsp_if.data_line);
                  fail_count++;
               end
               if (rsp_if.clock_line !== want.clock_line) begin
                  $error("clock_line: expected %0b, got %0b", want.clock_line,
                         rsp_if.clock_line);
                  fail_count++;
               end
               if (rsp_if.last_change !== want.last_change) begin
                  $error("last_change: expected %0b, got %0b", want.last_change,
                         rsp_if.last_change);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("led_driver_two_wire_sender regression: fail");
         $finish;
      end
   end

   task automatic add_command(logic [1:0] cmd, logic [3:0] level, logic [7:0] grid,
                              logic [7:0] segs);
      command_item_type it;
      it.cmd   = cmd;
      it.level = level;
      it.grid  = grid;
      it.segs  = segs;
      command_queue.push_back(it);
   endtask

   // wait for the sender queue and all pin changes to drain
   task automatic wait_until_quiet();
      while (command_queue.size() != 0 || req_if.valid || expected_pins.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PADDR_W'({idx, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_GRID_MAP_ENABLE:    cfg_mirror.grid_map_enable    = value[0];
         REG_GRID_MAP_LOWER:     cfg_mirror.grid_map_lower     = value[39:0];
         REG_GRID_MAP_UPPER:     cfg_mirror.grid_map_upper     = value[39:0];
         REG_SEGMENT_MAP_ENABLE: cfg_mirror.segment_map_enable = value[0];
         REG_SEGMENT_MAP:        cfg_mirror.segment_map        = value[23:0];
         default: ;
      endcase
   endtask

   task automatic load_config(bit grid_en, logic [39:0] lower, logic [39:0] upper,
                              bit seg_en, logic [23:0] seg_map);
      write_reg(REG_GRID_MAP_ENABLE, {63'd0, grid_en});
      write_reg(REG_GRID_MAP_LOWER, {24'd0, lower});
      write_reg(REG_GRID_MAP_UPPER, {24'd0, upper});
      write_reg(REG_SEGMENT_MAP_ENABLE, {63'd0, seg_en});
      write_reg(REG_SEGMENT_MAP, {40'd0, seg_map});
   endtask

   // mostly valid grid entries, a quarter of them skip
   function automatic logic [39:0] random_grid_map();
      logic [39:0] word;
      for (int k = 0; k < 8; k++)
         word[5*k +: 5] = ($urandom_range(99) < 75) ? 5'($urandom_range(15))
                                                    : 5'($urandom_range(31, 16));
      return word;
   endfunction

   function automatic command_item_type random_command();
      command_item_type it;
      int r;
      r = $urandom_range(99);
      if (r < 5) it.cmd = CMD_UNDEFINED;
      else if (r < 20) it.cmd = CMD_SETUP;
      else if (r < 45) it.cmd = CMD_BRIGHTNESS;
      else it.cmd = CMD_GRID;
      it.level = 4'($urandom_range(15));
      it.grid  = ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      it.segs  = 8'($urandom_range(255));
      return it;
   endfunction

   initial begin : stimulus
      command_item_type it;
      int counted;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.command          = CMD_SETUP;
      req_if.brightness_level = 4'd0;
      req_if.grid_number      = 8'd0;
      req_if.segment_bits     = 8'd0;
      rsp_if.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      cfg_mirror   = '0;
      data_level   = 1'b1;
      clock_level  = 1'b1;
      fail_count   = 0;
      cycle_count  = 0;
      tx_idle_pct  = 13;
      rx_idle_pct  = 80;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset configuration, all commands and field extremes
      add_command(CMD_SETUP, 4'hF, 8'hFF, 8'hFF);
      add_command(CMD_BRIGHTNESS, 4'd0, 8'd0, 8'd0);
      add_command(CMD_BRIGHTNESS, 4'd1, 8'd0, 8'd0);
      add_command(CMD_BRIGHTNESS, 4'd8, 8'd0, 8'd0);
      add_command(CMD_BRIGHTNESS, 4'd9, 8'd0, 8'd0);
      add_command(CMD_BRIGHTNESS, 4'd15, 8'hFF, 8'hFF);
      add_command(CMD_GRID, 4'd0, 8'd0, 8'h00);
      add_command(CMD_GRID, 4'hF, 8'd15, 8'hFF);
      add_command(CMD_GRID, 4'd0, 8'd16, 8'hA5);
      add_command(CMD_GRID, 4'd0, 8'd255, 8'h5A);
      add_command(CMD_UNDEFINED, 4'd5, 8'd3, 8'h3C);
      add_command(CMD_GRID, 4'd0, 8'd7, 8'hA5);
      wait_until_quiet();

      // directed: both maps on, with skipped grid entries
      load_config(1'b1, {5'd0, 5'd1, 5'd31, 5'd4, 5'd16, 5'd13, 5'd15, 5'd9},
                  {5'd15, 5'd0, 5'd7, 5'd20, 5'd3, 5'd2, 5'd1, 5'd8}, 1'b1, SEG_REVERSED);
      add_command(CMD_GRID, 4'd0, 8'd0, 8'h01);
      add_command(CMD_GRID, 4'd0, 8'd3, 8'hFF);
      add_command(CMD_GRID, 4'd0, 8'd5, 8'hFF);
      add_command(CMD_GRID, 4'd0, 8'd8, 8'h80);
      add_command(CMD_GRID, 4'd0, 8'd12, 8'h0F);
      add_command(CMD_GRID, 4'd0, 8'd15, 8'hC3);
      add_command(CMD_GRID, 4'd0, 8'd17, 8'h11);
      add_command(CMD_SETUP, 4'd0, 8'd0, 8'd0);
      wait_until_quiet();

      for (int round = 0; round < 6; round++) begin
         tx_idle_pct = (round < 2) ? 13 : (round < 4) ? 80 : 0;
         rx_idle_pct = (round < 2) ? 80 : (round < 4) ? 13 : 0;
         case (round)
            0: load_config(1'($urandom_range(1)), random_grid_map(), random_grid_map(),
                           1'($urandom_range(1)), 24'($urandom_range(24'hFFFFFF)));
            1: load_config(1'b1, 40'd0, 40'd0, 1'b1, 24'hFFFFFF);
            2: load_config(1'b1, 40'hFF_FFFF_FFFF, random_grid_map(), 1'b1, 24'd0);
            3: load_config(1'b1, random_grid_map(), random_grid_map(), 1'b1,
                           24'($urandom_range(24'hFFFFFF)));
            4: load_config(1'b0, random_grid_map(), random_grid_map(), 1'b1, SEG_IDENTITY);
            default: load_config(1'b1, random_grid_map(), random_grid_map(),
                                 1'($urandom_range(1)), 24'($urandom_range(24'hFFFFFF)));
         endcase
         counted = 0;
         while (counted < ROUND_ITEMS) begin
            it = random_command();
            command_queue.push_back(it);
            if (it.cmd != CMD_UNDEFINED && !(it.cmd == CMD_GRID && it.grid >= GRID_COUNT))
               counted++;
            // sender holds off mid-round until every pin change is out
            if ((round == 1 || round == 4) && counted == ROUND_ITEMS / 2) begin
               wait_until_quiet();
               counted++;
            end
         end
         wait_until_quiet();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_pins.size() == 0) begin
         $display("led_driver_two_wire_sender regression: pass");
      end else begin
         $display("led_driver_two_wire_sender regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
